FILE: rtl/pcpq_pkg.sv
// ----------------------------------------------------------------------------
// pcpq_pkg
// Shared types and codes for the path command parse queue.
// ----------------------------------------------------------------------------
package pcpq_pkg;

   // opcodes of an input item
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;
   localparam logic [1:0] OP_POP   = 2'd3;

   // configuration port
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic        REG_NO_ID   = 1'b0;   // word index of no_id_value

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] path_char;
   } req_type;

   typedef struct packed {
      logic        head_valid;
      logic [31:0] head_id;
      logic [7:0]  head_cmd_first;
      logic [7:0]  head_cmd_second;
      logic        next_valid;
      logic [31:0] next_id;
      logic [7:0]  next_cmd_first;
      logic [7:0]  next_cmd_second;
      logic        queue_full;
      logic        overflow_cleared;
   } rsp_type;

   // one queue entry as stored in memory
   typedef struct packed {
      logic [31:0] id;
      logic [15:0] cmd;
   } entry_type;

   // push request from the token parser to the queue
   typedef struct packed {
      logic        push;
      logic [31:0] id;
      logic [15:0] cmd;
   } push_type;

   // queue status after the last item
   typedef struct packed {
      logic head_valid;
      logic next_valid;
      logic full;
      logic cleared;
   } qstat_type;

endpackage

FILE: rtl/pcpq_ram.sv
// ----------------------------------------------------------------------------
// pcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcpq_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pcpq_parser.sv
// ----------------------------------------------------------------------------
// pcpq_parser
// Token parser: splits the path at commas, reads the signed decimal id and
// collects the first two bytes of each command token.
// ----------------------------------------------------------------------------
module pcpq_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [1:0]         opcode,
   input  logic [7:0]         path_char,
   output pcpq_pkg::push_type push_req
);
   import pcpq_pkg::*;

   localparam logic [7:0] CH_SEPARATOR = 8'h2C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;

   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   logic        is_cmd_ff, is_cmd_in;
   logic        open_ff, open_in;
   logic [1:0]  phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] pend_ff, pend_in;
   logic [1:0]  seen_ff, seen_in;
   logic [15:0] pair_ff, pair_in;

   logic        is_digit;
   logic        is_space;
   logic        do_close;
   logic [31:0] accum_x10;

   assign is_digit  = (path_char >= CH_ZERO) && (path_char <= CH_NINE);
   assign is_space  = (path_char == CH_SPACE) ||
                      ((path_char >= CH_TAB) && (path_char <= CH_CR));
   assign accum_x10 = {accum_ff[28:0], 3'b000} + {accum_ff[30:0], 1'b0};
   assign do_close  = (opcode == OP_END) ||
                      ((opcode == OP_CHAR) && (path_char == CH_SEPARATOR));

   assign push_req.push = step && do_close && open_ff && is_cmd_ff;
   assign push_req.id   = pend_ff;
   assign push_req.cmd  = pair_ff;

   always_comb begin
      is_cmd_in = is_cmd_ff;
      open_in   = open_ff;
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      accum_in  = accum_ff;
      pend_in   = pend_ff;
      seen_in   = seen_ff;
      pair_in   = pair_ff;
      if (opcode == OP_CLEAR) begin
         is_cmd_in = 1'b0;
         open_in   = 1'b0;
         phase_in  = PH_SKIP;
         neg_in    = 1'b0;
         accum_in  = '0;
         pend_in   = '0;
         seen_in   = '0;
         pair_in   = '0;
      end else if (do_close) begin
         // close the open token, then start a fresh one
         if (open_ff) begin
            if (!is_cmd_ff) begin
               pend_in = neg_ff ? (32'd0 - accum_ff) : accum_ff;
            end
            is_cmd_in = !is_cmd_ff;
         end
         if (opcode == OP_END) begin
            is_cmd_in = 1'b0;
         end
         open_in  = 1'b0;
         phase_in = PH_SKIP;
         neg_in   = 1'b0;
         accum_in = '0;
         seen_in  = '0;
         pair_in  = '0;
      end else if (opcode == OP_CHAR) begin
         open_in = 1'b1;
         if (is_cmd_ff) begin
            if (seen_ff == 2'd0) begin
               pair_in = {path_char, 8'h00};
               seen_in = 2'd1;
            end else if (seen_ff == 2'd1) begin
               pair_in = {pair_ff[15:8], path_char};
               seen_in = 2'd2;
            end
         end else if (phase_ff == PH_SKIP) begin
            if (is_space) begin
               phase_in = PH_SKIP;
            end else if ((path_char == CH_PLUS) || (path_char == CH_MINUS)) begin
               neg_in   = (path_char == CH_MINUS);
               phase_in = PH_DIGITS;
            end else if (is_digit) begin
               accum_in = 32'(path_char[3:0]);
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end else if (phase_ff == PH_DIGITS) begin
            if (is_digit) begin
               accum_in = accum_x10 + 32'(path_char[3:0]);
            end else begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_cmd_ff <= 1'b0;
         open_ff   <= 1'b0;
         phase_ff  <= PH_SKIP;
         neg_ff    <= 1'b0;
         accum_ff  <= '0;
         pend_ff   <= '0;
         seen_ff   <= '0;
         pair_ff   <= '0;
      end else if (step) begin
         is_cmd_ff <= is_cmd_in;
         open_ff   <= open_in;
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         accum_ff  <= accum_in;
         pend_ff   <= pend_in;
         seen_ff   <= seen_in;
         pair_ff   <= pair_in;
      end
   end

   ast_clear_resets_parser: assert property (@(posedge clock) disable iff (reset)
      (step && (opcode == OP_CLEAR)) |=> (!is_cmd_ff && !open_ff && (pend_ff == '0)))
      else $error("parser not cleared by clear item");

   ast_end_expects_id: assert property (@(posedge clock) disable iff (reset)
      (step && (opcode == OP_END)) |=> (!is_cmd_ff && !open_ff))
      else $error("parser not expecting id after end of path");

endmodule

FILE: rtl/pcpq_queue.sv
// ----------------------------------------------------------------------------
// pcpq_queue
// Ring queue of (id, command) entries. Two RAM copies share every write and
// are read at the head slot and the slot after it.
// ----------------------------------------------------------------------------
module pcpq_queue #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           opcode,
   input  pcpq_pkg::push_type   push_req,
   output pcpq_pkg::qstat_type  status,
   output pcpq_pkg::entry_type  head_entry,
   output pcpq_pkg::entry_type  next_entry
);
   import pcpq_pkg::*;

   localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned ENTRY_W = $bits(entry_type);

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             cleared_ff, cleared_in;

   logic             full;
   logic             empty;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [ENTRY_W-1:0] head_raw;
   logic [ENTRY_W-1:0] next_raw;

   assign empty = (rd_idx_ff == wr_idx_ff);
   assign full  = (wrap_next(wr_idx_ff) == rd_idx_ff);

   // a push into a full queue empties it and lands in slot zero
   assign wr_en        = push_req.push;
   assign wr_addr      = full ? '0 : wr_idx_ff;
   assign wr_entry.id  = push_req.id;
   assign wr_entry.cmd = push_req.cmd;

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      cleared_in = 1'b0;
      unique case (opcode)
         OP_CLEAR: begin
            rd_idx_in = '0;
            wr_idx_in = '0;
         end
         OP_POP: begin
            if (!empty) begin
               rd_idx_in = wrap_next(rd_idx_ff);
            end
         end
         default: begin
            if (push_req.push) begin
               if (full) begin
                  rd_idx_in  = '0;
                  wr_idx_in  = wrap_next('0);
                  cleared_in = 1'b1;
               end else begin
                  wr_idx_in = wrap_next(wr_idx_ff);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
         cleared_ff <= 1'b0;
      end else if (step) begin
         rd_idx_ff  <= rd_idx_in;
         wr_idx_ff  <= wr_idx_in;
         cleared_ff <= cleared_in;
      end
   end

   pcpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_idx_ff),
      .rd_data (head_raw)
   );

   pcpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (wrap_next(rd_idx_ff)),
      .rd_data (next_raw)
   );

   assign head_entry = entry_type'(head_raw);
   assign next_entry = entry_type'(next_raw);

   assign status.head_valid = !empty;
   assign status.next_valid = !empty && (wr_idx_ff != wrap_next(rd_idx_ff));
   assign status.full       = full;
   assign status.cleared    = cleared_ff;

   ast_overflow_restart: assert property (@(posedge clock) disable iff (reset)
      cleared_ff |-> ((rd_idx_ff == '0) && (wr_idx_ff == wrap_next('0))))
      else $error("overflow clear left pointers elsewhere than slot zero");

   ast_pop_empty_holds: assert property (@(posedge clock) disable iff (reset)
      (step && (opcode == OP_POP) && empty) |=> (empty && $stable(rd_idx_ff)))
      else $error("pop on empty queue moved the head");

endmodule

FILE: rtl/path_command_parse_queue_top.sv
// ----------------------------------------------------------------------------
// path_command_parse_queue_top
// Parses a comma-separated path byte stream into a ring queue of
// (id, command) entries and reports head, next entry and flags per item.
//
//   Port group  Direction  Handshake          Payload
//   req_        in         req_valid/ready    req_type  (opcode, path_char)
//   rsp_        out        rsp_valid/ready    rsp_type  (head, next, flags)
//   csr_        in/out     APB psel/penable   no_id_value at byte address 0
//
// An item goes through accept and update, RAM read of head and next slot,
// load of the result register; the registered RAM read sets that order.
// The result register frees the input side: the next item is taken while
// a result still waits. Reset is synchronous; it empties the queue and the
// parser and clears no_id_value. The RAM contents are not cleared.
// ----------------------------------------------------------------------------
module path_command_parse_queue_top #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pcpq_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pcpq_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcpq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pcpq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pcpq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import pcpq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] no_id_ff;

   logic        step;
   logic        load;
   push_type    push_req;
   qstat_type   status;
   entry_type   head_entry;
   entry_type   next_entry;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_NO_ID) ? no_id_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         no_id_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_NO_ID)) begin
         no_id_ff <= csr_pwdata;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign step      = req_valid && req_ready;
   assign load      = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   pcpq_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .opcode    (req_data.opcode),
      .path_char (req_data.path_char),
      .push_req  (push_req)
   );

   pcpq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .opcode     (req_data.opcode),
      .push_req   (push_req),
      .status     (status),
      .head_entry (head_entry),
      .next_entry (next_entry)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (step) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in.head_valid       = status.head_valid;
      rsp_in.head_id          = status.head_valid ? head_entry.id : no_id_ff;
      rsp_in.head_cmd_first   = status.head_valid ? head_entry.cmd[15:8] : 8'h00;
      rsp_in.head_cmd_second  = status.head_valid ? head_entry.cmd[7:0] : 8'h00;
      rsp_in.next_valid       = status.next_valid;
      rsp_in.next_id          = status.next_valid ? next_entry.id : no_id_ff;
      rsp_in.next_cmd_first   = status.next_valid ? next_entry.cmd[15:8] : 8'h00;
      rsp_in.next_cmd_second  = status.next_valid ? next_entry.cmd[7:0] : 8'h00;
      rsp_in.queue_full       = status.full;
      rsp_in.overflow_cleared = status.cleared;
   end

   // hold the result until taken; a new load replaces a taken one
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   ast_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      step |=> (state_ff == ST_READ))
      else $error("accepted item did not start a memory read");

   ast_read_then_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_RESP))
      else $error("memory read not followed by result load");

endmodule
